>>> rtl/upsf_pkg.sv
// shared types, constants and byte classification functions of the utf-8 punctuation strip filter
// no dependencies
package upsf_pkg;

   localparam int ByteW  = 8;
   localparam int CountW = 4;

   localparam logic [ByteW-1:0]  LeadA    = 8'hE3;
   localparam logic [ByteW-1:0]  SecondA  = 8'h80;
   localparam logic [ByteW-1:0]  LeadB    = 8'hEF;
   localparam logic [ByteW-1:0]  SecondB1 = 8'hBC;
   localparam logic [ByteW-1:0]  SecondB2 = 8'hBD;
   localparam logic [CountW-1:0] CountMax = 4'd15;
   localparam logic [CountW-1:0] MinKeptReset = 4'd3;

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_LEAD = 2'd1,
      HOLD_PAIR = 2'd2
   } hold_type;

   typedef struct packed {
      logic [ByteW-1:0] kept_byte;
      logic             byte_valid;
      logic             last_of_run;
      logic             text_done;
      logic             too_short;
   } result_word_type;

   // up to two result words produced by one classified byte
   typedef struct packed {
      logic [1:0]      n;
      result_word_type w0;
      result_word_type w1;
   } push_type;

   function automatic logic is_punct(input logic [ByteW-1:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic logic is_lead(input logic [ByteW-1:0] c);
      return (c == LeadA) || (c == LeadB);
   endfunction

   function automatic logic pair_matches(input logic [ByteW-1:0] lead,
                                         input logic [ByteW-1:0] second);
      return ((lead == LeadA) && (second == SecondA)) ||
             ((lead == LeadB) && ((second == SecondB1) || (second == SecondB2)));
   endfunction

endpackage

>>> rtl/upsf_if.sv
// valid/ready channel interfaces: text input, filtered output, threshold write
// depends on nothing
interface upsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface upsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] kept_byte;
   logic       byte_valid;
   logic       last_of_run;
   logic       text_done;
   logic       too_short;

   modport source (output valid, output kept_byte, output byte_valid, output last_of_run,
                   output text_done, output too_short, input ready);
   modport sink   (input valid, input kept_byte, input byte_valid, input last_of_run,
                   input text_done, input too_short, output ready);
endinterface

interface upsf_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] min_kept_length;

   modport source (output valid, output min_kept_length, input ready);
   modport sink   (input valid, input min_kept_length, output ready);
endinterface

>>> rtl/upsf_classify.sv
// input register, held-lead tracking, kept-byte count and threshold register
// depends on upsf_pkg and upsf_if
module upsf_classify (
   input  logic               clock,
   input  logic               reset,
   upsf_req_if.sink           req_bus,
   upsf_csr_if.sink           csr_bus,
   input  logic               space_ok,
   output upsf_pkg::push_type push_out
);
   import upsf_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0]    s1_byte_ff;
   logic                s1_end_ff;
   hold_type            hold_ff, hold_in;
   logic [ByteW-1:0]    lead_ff, lead_in;
   logic [CountW-1:0]   kept_count_ff, kept_count_in;
   logic [CountW-1:0]   min_kept_ff;

   logic                advance;
   logic                req_fire;
   logic                fresh_hold, fresh_emit, matched;
   logic                e0_v, e1_v;
   logic [ByteW-1:0]    e0_b, e1_b;
   logic [1:0]          k;
   logic [CountW:0]     sum;
   logic [CountW-1:0]   cnt_sat;
   logic                short_flag;

   assign advance       = s1_valid_ff && space_ok;
   assign req_bus.ready = !s1_valid_ff || space_ok;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      fresh_hold = !is_punct(s1_byte_ff) && is_lead(s1_byte_ff) && !s1_end_ff;
      fresh_emit = !is_punct(s1_byte_ff) && !fresh_hold;
      matched    = pair_matches(lead_ff, s1_byte_ff);
      e0_v    = 1'b0;
      e0_b    = s1_byte_ff;
      e1_v    = 1'b0;
      e1_b    = s1_byte_ff;
      hold_in = HOLD_NONE;
      lead_in = lead_ff;
      case (hold_ff)
         HOLD_NONE: begin
            if (fresh_hold) begin
               hold_in = HOLD_LEAD;
               lead_in = s1_byte_ff;
            end else if (fresh_emit) begin
               e0_v = 1'b1;
            end
         end
         HOLD_LEAD: begin
            e0_b = lead_ff;
            if (matched) begin
               if (s1_end_ff) begin
                  e0_v = 1'b1;
                  e1_v = 1'b1;
               end else begin
                  hold_in = HOLD_PAIR;
               end
            end else begin
               e0_v = 1'b1;
               if (fresh_hold) begin
                  hold_in = HOLD_LEAD;
                  lead_in = s1_byte_ff;
               end else if (fresh_emit) begin
                  e1_v = 1'b1;
               end
            end
         end
         default: begin
            hold_in = HOLD_NONE;
         end
      endcase
      if (s1_end_ff) begin
         hold_in = HOLD_NONE;
         lead_in = '0;
      end
   end

   always_comb begin
      k          = {1'b0, e0_v} + {1'b0, e1_v};
      sum        = {1'b0, kept_count_ff} + {3'b000, k};
      cnt_sat    = (sum > {1'b0, CountMax}) ? CountMax : sum[CountW-1:0];
      short_flag = cnt_sat < min_kept_ff;
      kept_count_in = s1_end_ff ? '0 : cnt_sat;

      push_out.w0.kept_byte   = e0_v ? e0_b : '0;
      push_out.w0.byte_valid  = e0_v;
      push_out.w0.last_of_run = (k != 2'd2);
      push_out.w0.text_done   = s1_end_ff && (k != 2'd2);
      push_out.w0.too_short   = s1_end_ff && (k != 2'd2) && short_flag;
      push_out.w1.kept_byte   = e1_v ? e1_b : '0;
      push_out.w1.byte_valid  = e1_v;
      push_out.w1.last_of_run = 1'b1;
      push_out.w1.text_done   = s1_end_ff;
      push_out.w1.too_short   = s1_end_ff && short_flag;
      if (!advance) begin
         push_out.n = 2'd0;
      end else if (k == 2'd0 && s1_end_ff) begin
         push_out.n = 2'd1;
      end else begin
         push_out.n = k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         hold_ff       <= HOLD_NONE;
         lead_ff       <= '0;
         kept_count_ff <= '0;
         min_kept_ff   <= MinKeptReset;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            hold_ff       <= hold_in;
            lead_ff       <= lead_in;
            kept_count_ff <= kept_count_in;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            min_kept_ff <= csr_bus.min_kept_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_bus.text_byte;
         s1_end_ff  <= req_bus.end_of_text;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && s1_end_ff |=> kept_count_ff == '0 && hold_ff == HOLD_NONE)
      else $error("state not cleared after end of text");

   a_third_drops: assert property (@(posedge clock) disable iff (reset)
      advance && hold_ff == HOLD_PAIR |-> !push_out.w0.byte_valid && !push_out.w1.byte_valid)
      else $error("third byte of a sequence produced output");

   a_pair_valid: assert property (@(posedge clock) disable iff (reset)
      push_out.n == 2'd2 |-> push_out.w0.byte_valid && push_out.w1.byte_valid)
      else $error("two-word push with an empty word");

   a_no_hold_after_pair: assert property (@(posedge clock) disable iff (reset)
      advance && hold_ff == HOLD_PAIR |=> hold_ff == HOLD_NONE)
      else $error("hold state did not clear after third byte");

endmodule

>>> rtl/upsf_out_queue.sv
// result queue taking up to two words per cycle and handing out one word per handshake
// depends on upsf_pkg and upsf_if
module upsf_out_queue #(
   parameter int Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  upsf_pkg::push_type push_in,
   output logic               space_ok,
   upsf_rsp_if.source         rsp_bus
);
   import upsf_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] SpaceLim = CntW'(Depth - 2);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   result_word_type   mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              pop;
   result_word_type   head;

   function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
      return (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   assign space_ok      = count_ff <= SpaceLim;
   assign head          = mem[rd_ptr_ff];
   assign rsp_bus.valid       = count_ff != '0;
   assign rsp_bus.kept_byte   = head.kept_byte;
   assign rsp_bus.byte_valid  = head.byte_valid;
   assign rsp_bus.last_of_run = head.last_of_run;
   assign rsp_bus.text_done   = head.text_done;
   assign rsp_bus.too_short   = head.too_short;
   assign pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_next   = wrap_inc(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (push_in.n == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (push_in.n == 2'd2) begin
         wr_ptr_in = wrap_inc(wr_next);
      end
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_in.n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.n != 2'd0) begin
         mem[wr_ptr_ff] <= push_in.w0;
      end
      if (push_in.n == 2'd2) begin
         mem[wr_next] <= push_in.w1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.n != 2'd0 |-> space_ok)
      else $error("push into a full queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && count_ff == CntW'(1) && push_in.n == 2'd0 |=> !rsp_bus.valid)
      else $error("queue not empty after last word taken");

endmodule

>>> rtl/utf8_punctuation_strip_filter.sv
// top level of the utf-8 punctuation strip filter
// depends on upsf_pkg, upsf_if, upsf_classify and upsf_out_queue
//
// Takes one text byte per cycle on req_bus and passes on every byte except ascii punctuation
// and three-byte sequences starting E3 80, EF BC or EF BD; a lead byte or lead pair is held
// until the next byte decides it and is flushed if the text ends there. Each word goes into
// an input register, is classified there once the queue has room and lands in a Depth-entry
// result queue that drives rsp_bus. The sustained rate is one byte per cycle; a byte that
// flushes a held lead can yield two result words, and input stalls while the
// queue has fewer than two free entries. The final word of a text carries text_done and, if
// fewer than min_kept_length bytes were kept (count saturating at 15), too_short. A text that
// ends with nothing left to emit gives one word with byte_valid low. csr_bus is always ready.
module utf8_punctuation_strip_filter #(
   parameter int Depth = 4
) (
   input  logic        clock,
   input  logic        reset,
   upsf_req_if.sink    req_bus,
   upsf_csr_if.sink    csr_bus,
   upsf_rsp_if.source  rsp_bus
);
   import upsf_pkg::*;

   push_type push;
   logic     space_ok;

   upsf_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .space_ok (space_ok),
      .push_out (push)
   );

   upsf_out_queue #(
      .Depth (Depth)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .space_ok (space_ok),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> tb/upsf_score_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the utf-8 punctuation strip filter: predicts and checks result words
// depends on upsf_pkg
package upsf_score_pkg;
   import upsf_pkg::*;

   class strip_scoreboard;
      hold_type          hold_state;
      logic [ByteW-1:0]  lead_byte;
      logic [CountW-1:0] kept_total;
      logic [CountW-1:0] min_length;
      result_word_type   expected_words[$];
      result_word_type   run_words[$];
      int                errors;

      function new();
         hold_state = HOLD_NONE;
         lead_byte  = '0;
         kept_total = '0;
         min_length = MinKeptReset;
         errors     = 0;
      endfunction

      static function logic is_symbol(logic [ByteW-1:0] b);
         return b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
      endfunction

      function void set_min_length(logic [CountW-1:0] v);
         min_length = v;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void keep(logic [ByteW-1:0] b);
         result_word_type w;
         w = '0;
         w.kept_byte  = b;
         w.byte_valid = 1'b1;
         run_words.push_back(w);
         if (kept_total != CountMax) kept_total++;
      endfunction

      function void judge_alone(logic [ByteW-1:0] b, logic eot);
         if (is_symbol(b)) return;
         if ((b == LeadA || b == LeadB) && !eot) begin
            lead_byte  = b;
            hold_state = HOLD_LEAD;
            return;
         end
         keep(b);
      endfunction

      // predict the words caused by one accepted input word
      function void note_text_byte(logic [ByteW-1:0] b, logic eot);
         logic seq_second;
         run_words.delete();
         case (hold_state)
            HOLD_NONE: judge_alone(b, eot);
            HOLD_LEAD: begin
               seq_second = (lead_byte == LeadA && b == SecondA) ||
                            (lead_byte == LeadB && (b == SecondB1 || b == SecondB2));
               if (seq_second && eot) begin
                  hold_state = HOLD_NONE;
                  keep(lead_byte);
                  keep(b);
               end else if (seq_second) begin
                  hold_state = HOLD_PAIR;
               end else begin
                  hold_state = HOLD_NONE;
                  keep(lead_byte);
                  judge_alone(b, eot);
               end
            end
            default: hold_state = HOLD_NONE;
         endcase
         if (eot) begin
            if (run_words.size() == 0) run_words.push_back('0);
            run_words[$].text_done = 1'b1;
            run_words[$].too_short = (kept_total < min_length);
            hold_state = HOLD_NONE;
            lead_byte  = '0;
            kept_total = '0;
         end
         if (run_words.size() > 0) run_words[$].last_of_run = 1'b1;
         foreach (run_words[i]) expected_words.push_back(run_words[i]);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_word(result_word_type got);
         result_word_type exp_w;
         if (expected_words.size() == 0) begin
            $display("%0t: word with none expected, got %0h", $time, got);
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         compare_field("kept_byte", exp_w.kept_byte, got.kept_byte);
         compare_field("byte_valid", exp_w.byte_valid, got.byte_valid);
         compare_field("last_of_run", exp_w.last_of_run, got.last_of_run);
         compare_field("text_done", exp_w.text_done, got.text_done);
         compare_field("too_short", exp_w.too_short, got.too_short);
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// top of the strip filter testbench: clock, reset, drivers, monitor and watchdog
// depends on upsf_pkg, upsf_if, upsf_score_pkg and utf8_punctuation_strip_filter
module tb_top;
   import upsf_pkg::*;
   import upsf_score_pkg::*;

   typedef logic [7:0] text_q_type[$];

   localparam int IdlePct    = 18;
   localparam int StallLimit = 1000;
   localparam int DrainWait  = 10;

   logic clock;
   logic reset;
   logic no_idle;
   int   stall_cycles;

   strip_scoreboard sb;

   upsf_req_if req_bus();
   upsf_rsp_if rsp_bus();
   upsf_csr_if csr_bus();

   utf8_punctuation_strip_filter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= IdlePct);
      end
   end

   always @(posedge clock) begin
      result_word_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kept_byte   = rsp_bus.kept_byte;
         got.byte_valid  = rsp_bus.byte_valid;
         got.last_of_run = rsp_bus.last_of_run;
         got.text_done   = rsp_bus.text_done;
         got.too_short   = rsp_bus.too_short;
         sb.check_word(got);
      end
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_word(logic [7:0] b, logic eot);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IdlePct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= b;
      req_bus.end_of_text <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_text_byte(b, eot);
   endtask

   task automatic send_text(text_q_type text);
      foreach (text[i]) send_word(text[i], i == text.size() - 1);
   endtask

   // wait for every predicted word, then let dropped bytes clear the pipeline
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_min_length(logic [3:0] v);
      drain();
      @(negedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.min_kept_length <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.set_min_length(v);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (strip_scoreboard::is_symbol(b) || b == LeadA || b == LeadB);
      return b;
   endfunction

   function automatic logic [7:0] symbol_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (!strip_scoreboard::is_symbol(b));
      return b;
   endfunction

   // mostly well-formed text: plain bytes, punctuation, full dropped sequences
   task automatic send_random_text(output int sent);
      text_q_type text;
      int         len;
      int         pick;
      len = ($urandom_range(7) == 0) ? $urandom_range(16, 30) : $urandom_range(1, 12);
      while (text.size() < len) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            text.push_back(plain_byte());
         end else if (pick < 55) begin
            text.push_back(symbol_byte());
         end else if (pick < 75) begin
            if ($urandom_range(1)) begin
               text.push_back(LeadA);
               text.push_back(SecondA);
            end else begin
               text.push_back(LeadB);
               text.push_back($urandom_range(1) ? SecondB1 : SecondB2);
            end
            text.push_back(8'($urandom_range(255)));
         end else if (pick < 85) begin
            text.push_back($urandom_range(1) ? LeadA : LeadB);
         end else begin
            text.push_back(8'($urandom_range(255)));
         end
      end
      send_text(text);
      sent = text.size();
   endtask

   task automatic random_phase(int items);
      int done_items;
      int sent;
      done_items = 0;
      while (done_items < items) begin
         send_random_text(sent);
         done_items += sent;
      end
   endtask

   initial begin
      sb = new();
      no_idle                 = 1'b0;
      stall_cycles            = 0;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.text_byte       <= '0;
      req_bus.end_of_text     <= 1'b0;
      csr_bus.valid           <= 1'b0;
      csr_bus.min_kept_length <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // punctuation range edges, zero byte and all-ones byte
      send_text('{8'h21, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7E, 8'h00, 8'hFF});
      // dropped sequences, unmatched lead, lead followed by lead, third byte at end
      send_text('{LeadB, SecondB1, 8'h00, LeadB, SecondB2, 8'hFF, LeadA, 8'h41,
                  LeadB, LeadA, SecondA, 8'h21});
      // lone lead at end, lead pair at end, text with nothing kept
      send_text('{LeadA});
      send_text('{LeadB, SecondB2});
      send_text('{8'h2A});

      random_phase(20);
      write_min_length(4'd0);
      random_phase(20);
      write_min_length(4'd15);
      no_idle = 1'b1;
      random_phase(20);
      no_idle = 1'b0;
      write_min_length(4'($urandom_range(1, 14)));
      random_phase(20);
      write_min_length(4'd3);
      random_phase(20);
      drain();

      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
